>>> hw/rtl/dpm_pkg.sv
package dpm_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SIDE_DEF   = 9;
    localparam int VALUE_BITS_DEF = 8;

    // Fixed field widths.
    localparam int POS_BITS  = 7;
    localparam int SIDE_BITS = 4;
    localparam int RC_BITS   = 4;

    // The two plane sides the block accepts.
    localparam logic [SIDE_BITS-1:0] SIDE_SMALL = 4'd7;
    localparam logic [SIDE_BITS-1:0] SIDE_LARGE = 4'd9;
    localparam logic [POS_BITS-1:0]  CELLS_SMALL = 7'd49;
    localparam logic [POS_BITS-1:0]  CELLS_LARGE = 7'd81;

    // Reciprocals that turn a division by the side into a multiply and shift.
    // They are exact for every position inside a plane of that side.
    localparam logic [7:0] RECIP_SMALL = 8'd147;
    localparam int         SHIFT_SMALL = 10;
    localparam logic [7:0] RECIP_LARGE = 8'd57;
    localparam int         SHIFT_LARGE = 9;

    // Result queue depth.
    localparam int FIFO_DEPTH = 3;

    typedef enum logic {
        OP_CELL  = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic {
        REG_BOARD_SIDE = 1'b0,
        REG_SYMMETRY   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        SYM_IDENTITY   = 3'd0,
        SYM_ROT90      = 3'd1,
        SYM_ROT180     = 3'd2,
        SYM_ROT270     = 3'd3,
        SYM_REFLECT    = 3'd4,
        SYM_REF_ROT90  = 3'd5,
        SYM_REF_ROT180 = 3'd6,
        SYM_REF_ROT270 = 3'd7
    } sym_t;

    // Everything about one result except its value.
    typedef struct packed {
        logic [POS_BITS-1:0] position;
        logic                plane_end;
        logic                valid;
        logic                error;
    } meta_t;

    // v * side for the two accepted sides, as a shift and an add or subtract.
    function automatic logic [POS_BITS-1:0] times_side(input logic [RC_BITS-1:0] v,
                                                       input logic [SIDE_BITS-1:0] side);
        logic [POS_BITS-1:0] v8;
        v8 = {v, 3'b000};
        if (side == SIDE_LARGE) begin
            return v8 + POS_BITS'(v);
        end
        return v8 - POS_BITS'(v);
    endfunction

endpackage

>>> hw/rtl/dpm_plane_mem.sv
module dpm_plane_mem
    import dpm_pkg::*;
#(
    parameter int DEPTH      = 2 * MAX_SIDE_DEF * MAX_SIDE_DEF,
    parameter int ADDR_BITS  = $clog2(DEPTH),
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_BITS-1:0]  waddr,
    input  logic [VALUE_BITS-1:0] wdata,
    input  logic                  re,
    input  logic [ADDR_BITS-1:0]  raddr,
    output logic [VALUE_BITS-1:0] rdata
);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/dpm_index_ctl.sv
module dpm_index_ctl
    import dpm_pkg::*;
#(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CELLS      = MAX_SIDE * MAX_SIDE,
    parameter int DEPTH      = 2 * CELLS,
    parameter int ADDR_BITS  = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  op,
    input  logic [VALUE_BITS-1:0] cell_value,
    input  logic [SIDE_BITS-1:0]  side,
    input  sym_t                  sym,
    input  logic                  side_wr,
    input  logic [SIDE_BITS-1:0]  side_wdata,
    output logic                  busy,
    output logic                  mem_we,
    output logic [ADDR_BITS-1:0]  mem_waddr,
    output logic [VALUE_BITS-1:0] mem_wdata,
    output logic [ADDR_BITS-1:0]  mem_raddr,
    output meta_t                 meta
);

    logic [POS_BITS-1:0]  idx_reg, idx_next;
    logic [RC_BITS-1:0]   row_reg, row_next;
    logic [RC_BITS-1:0]   col_reg, col_next;
    logic                 bank_reg, bank_next;
    logic                 present_reg, present_next;
    logic                 clear_reg;
    logic [ADDR_BITS-1:0] clr_addr_reg;

    logic                 side_ok;
    logic [POS_BITS-1:0]  cells;
    logic                 in_range;
    logic [POS_BITS-1:0]  pos;
    logic [RC_BITS-1:0]   row;
    logic [RC_BITS-1:0]   col;
    logic [RC_BITS-1:0]   mx;
    logic                 last;
    logic [RC_BITS-1:0]   tr;
    logic [RC_BITS-1:0]   tc;
    logic [POS_BITS-1:0]  target;
    logic [14:0]          prod_small;
    logic [12:0]          prod_large;
    logic [RC_BITS-1:0]   resync_row;
    logic [POS_BITS-1:0]  resync_rem;

    assign side_ok  = (side == SIDE_SMALL || side == SIDE_LARGE)
                      && ({28'd0, side} <= 32'(MAX_SIDE));
    assign cells    = (side == SIDE_LARGE) ? CELLS_LARGE : CELLS_SMALL;
    assign in_range = idx_reg < cells;
    assign pos      = in_range ? idx_reg : '0;
    assign row      = in_range ? row_reg : '0;
    assign col      = in_range ? col_reg : '0;
    assign mx       = side - 4'd1;
    assign last     = pos == (cells - 7'd1);

    always_comb begin
        case (sym)
            SYM_IDENTITY:   begin tr = row;      tc = col;      end
            SYM_ROT90:      begin tr = col;      tc = mx - row; end
            SYM_ROT180:     begin tr = mx - row; tc = mx - col; end
            SYM_ROT270:     begin tr = mx - col; tc = row;      end
            SYM_REFLECT:    begin tr = row;      tc = mx - col; end
            SYM_REF_ROT90:  begin tr = mx - col; tc = mx - row; end
            SYM_REF_ROT180: begin tr = mx - row; tc = col;      end
            default:        begin tr = col;      tc = row;      end
        endcase
    end

    assign target = times_side(tr, side) + POS_BITS'(tc);

    // Outside the clearing sweep, write and read always touch opposite banks, and a write
    // commits at the same edge its item is accepted, so no later read can see a stale entry.
    always_comb begin
        mem_we    = clear_reg || (step && side_ok && op == OP_CELL);
        mem_wdata = clear_reg ? '0 : cell_value;
        if (clear_reg) begin
            mem_waddr = clr_addr_reg;
        end else begin
            mem_waddr = ADDR_BITS'(target) + (bank_reg ? ADDR_BITS'(CELLS) : '0);
        end
        mem_raddr = ADDR_BITS'(pos) + (bank_reg ? '0 : ADDR_BITS'(CELLS));
    end

    always_comb begin
        meta.position  = side_ok ? pos : idx_reg;
        meta.plane_end = side_ok && last;
        meta.valid     = side_ok && present_reg;
        meta.error     = !side_ok;
    end

    // Row and column of the current index under a newly written side.
    assign prod_small = 15'(idx_reg) * 15'(RECIP_SMALL);
    assign prod_large = 13'(idx_reg) * 13'(RECIP_LARGE);
    assign resync_row = (side_wdata == SIDE_SMALL) ? prod_small[SHIFT_SMALL +: RC_BITS]
                                                   : prod_large[SHIFT_LARGE +: RC_BITS];
    assign resync_rem = idx_reg - times_side(resync_row, side_wdata);

    always_comb begin
        idx_next     = idx_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        bank_next    = bank_reg;
        present_next = present_reg;
        if (side_wr) begin
            row_next = resync_row;
            col_next = resync_rem[RC_BITS-1:0];
        end else if (step && side_ok) begin
            if (last) begin
                idx_next     = '0;
                row_next     = '0;
                col_next     = '0;
                bank_next    = !bank_reg;
                present_next = 1'b1;
            end else begin
                idx_next = pos + 7'd1;
                if (col == mx) begin
                    col_next = '0;
                    row_next = row + 4'd1;
                end else begin
                    col_next = col + 4'd1;
                    row_next = row;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            bank_reg    <= 1'b0;
            present_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            bank_reg    <= bank_next;
            present_reg <= present_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clear_reg) begin
            if (clr_addr_reg == ADDR_BITS'(DEPTH - 1)) begin
                clear_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign busy = clear_reg;

endmodule

>>> hw/rtl/dpm_out_fifo.sv
module dpm_out_fifo
    import dpm_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int DEPTH      = FIFO_DEPTH,
    parameter int PTR_BITS   = $clog2(DEPTH),
    parameter int CNT_BITS   = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [VALUE_BITS-1:0] push_value,
    input  meta_t                 push_meta,
    input  logic                  pop,
    output logic [CNT_BITS-1:0]   count,
    output logic [VALUE_BITS-1:0] head_value,
    output meta_t                 head_meta
);

    logic [VALUE_BITS-1:0] value_q [DEPTH];
    meta_t                 meta_q  [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            value_q[wr_ptr_reg] <= push_value;
            meta_q[wr_ptr_reg]  <= push_meta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign count      = count_reg;
    assign head_value = value_q[rd_ptr_reg];
    assign head_meta  = meta_q[rd_ptr_reg];

endmodule

>>> hw/rtl/square_grid_dihedral_permuter.sv
// A result word is registered in the read stage and then queued before it appears on m_.
// Throughput: one input word and one result word per cycle while m_ready is held high, limited
// by the single write and read ports of the plane memory; a three-entry result queue absorbs
// output stalls. Reset: synchronous, active-low aresetn. After reset the block sweeps every entry
// of the plane memory to zero with s_ready low; APB writes are taken.
module square_grid_dihedral_permuter
    import dpm_pkg::*;
#(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Input channel.
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic signed [VALUE_BITS-1:0] s_cell_value,
    // Result channel.
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_out_value,
    output logic [POS_BITS-1:0]          m_out_position,
    output logic                         m_plane_end,
    output logic                         m_out_valid,
    output logic                         m_config_error
);

    localparam int CELLS     = MAX_SIDE * MAX_SIDE;
    localparam int DEPTH     = 2 * CELLS;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_BITS  = $clog2(FIFO_DEPTH + 2);

    // Configuration registers. The register index is taken from paddr[2]; the low
    // address bits are ignored, as on a word-aligned bus.
    logic [SIDE_BITS-1:0] side_reg;
    sym_t                 sym_reg;
    reg_idx_t             reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_LARGE;
            sym_reg  <= SYM_IDENTITY;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_BOARD_SIDE: side_reg <= pwdata[SIDE_BITS-1:0];
                REG_SYMMETRY:   sym_reg  <= sym_t'(pwdata[2:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BOARD_SIDE: prdata = {28'd0, side_reg};
            REG_SYMMETRY:   prdata = {29'd0, sym_reg};
            default:        prdata = '0;
        endcase
    end

    // Index control: walks the plane position, maps each cell to its
    // transformed address in the write bank, and reads the same position
    // of the other bank. It also runs the clearing sweep after reset.
    logic                  busy;
    logic                  s_accept;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [ADDR_BITS-1:0]  mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;
    meta_t                 meta;

    assign s_accept = s_valid && s_ready;

    dpm_index_ctl #(
        .MAX_SIDE   (MAX_SIDE),
        .VALUE_BITS (VALUE_BITS),
        .CELLS      (CELLS),
        .DEPTH      (DEPTH),
        .ADDR_BITS  (ADDR_BITS)
    ) u_index_ctl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (s_accept),
        .op         (s_op),
        .cell_value (s_cell_value),
        .side       (side_reg),
        .sym        (sym_reg),
        .side_wr    (cfg_wr && reg_idx == REG_BOARD_SIDE),
        .side_wdata (pwdata[SIDE_BITS-1:0]),
        .busy       (busy),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .meta       (meta)
    );

    // Both ping-pong banks live in one memory: bank 0 in the lower half.
    dpm_plane_mem #(
        .DEPTH      (DEPTH),
        .ADDR_BITS  (ADDR_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_plane_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (s_accept),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Read stage: the word's result fields are registered here alongside the memory read,
    // then both go into the result queue together.
    logic  rd_valid_reg;
    meta_t rd_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_meta_reg <= meta;
        end
    end

    logic [CNT_BITS-1:0]   fifo_count;
    logic [VALUE_BITS-1:0] head_value;
    meta_t                 head_meta;
    logic [OCC_BITS-1:0]   occupancy;

    dpm_out_fifo #(
        .VALUE_BITS (VALUE_BITS),
        .DEPTH      (FIFO_DEPTH)
    ) u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (rd_valid_reg),
        .push_value (rd_meta_reg.error ? '0 : mem_rdata),
        .push_meta  (rd_meta_reg),
        .pop        (m_valid && m_ready),
        .count      (fifo_count),
        .head_value (head_value),
        .head_meta  (head_meta)
    );

    // A new word is taken only when the queue has room for it and for the
    // word already in the read stage, so a read result never has to be held.
    assign occupancy = OCC_BITS'(fifo_count) + OCC_BITS'(rd_valid_reg);
    assign s_ready   = !busy && (occupancy < OCC_BITS'(FIFO_DEPTH));

    assign m_valid        = fifo_count != '0;
    assign m_out_value    = head_value;
    assign m_out_position = head_meta.position;
    assign m_plane_end    = head_meta.plane_end;
    assign m_out_valid    = head_meta.valid;
    assign m_config_error = head_meta.error;

endmodule

>>> hw/rtl/dpm_checker.sv
module dpm_checker
    import dpm_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [VALUE_BITS-1:0] m_out_value,
    input logic [POS_BITS-1:0]          m_out_position,
    input logic                         m_plane_end,
    input logic                         m_out_valid,
    input logic                         m_config_error
);

    // Reset empties the result path and starts the memory sweep.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or input channel active right after reset");

    // A stalled result word holds its fields.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value)
            && $stable(m_out_position) && $stable(m_plane_end))
        else $error("stalled result word changed");

    // A side error forces the value and flags to zero.
    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_config_error |-> m_out_value == '0 && !m_plane_end && !m_out_valid)
        else $error("error result carries data");

    // Plane end falls only on the last cell of a 7 or 9 wide plane.
    a_plane_end_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_plane_end |-> m_out_position == 7'd48 || m_out_position == 7'd80)
        else $error("plane end at a wrong position");

endmodule

bind square_grid_dihedral_permuter dpm_checker #(.VALUE_BITS(VALUE_BITS)) u_dpm_checker (.*);

>>> tb/tb_square_grid_dihedral_permuter.sv
`timescale 1ns / 1ps

module tb_square_grid_dihedral_permuter;
    import dpm_pkg::*;

    localparam int PLANE_CELLS  = MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int RANDOM_WORDS = 1800;
    // Longest legal stretch without a handshake is the forced receiver hold-off
    // plus a long idle gap, or the memory sweep after reset; this is well above both.
    localparam int STUCK_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;

    // One input word as the driver offers it.
    typedef struct packed {
        op_t                             op;
        logic signed [VALUE_BITS_DEF-1:0] value;
    } cell_word_t;

    // One result word as the predictor works it out.
    typedef struct packed {
        logic signed [VALUE_BITS_DEF-1:0] value;
        logic [POS_BITS-1:0]              position;
        logic                             plane_end;
        logic                             from_plane;
        logic                             side_error;
    } permuted_cell_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic                             s_valid      = 1'b0;
    logic                             s_ready;
    logic                             s_op         = 1'b0;
    logic signed [VALUE_BITS_DEF-1:0] s_cell_value = '0;

    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic signed [VALUE_BITS_DEF-1:0] m_out_value;
    logic [POS_BITS-1:0]              m_out_position;
    logic                             m_plane_end;
    logic                             m_out_valid;
    logic                             m_config_error;

    square_grid_dihedral_permuter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_cell_value  (s_cell_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_value   (m_out_value),
        .m_out_position(m_out_position),
        .m_plane_end   (m_plane_end),
        .m_out_valid   (m_out_valid),
        .m_config_error(m_config_error)
    );

    always #2 aclk = ~aclk;

    // Words waiting to be offered, and results the block still owes us.
    cell_word_t     pending_words[$];
    permuted_cell_t expected_results[$];

    // Our own copy of the block state. The configuration copy is only touched
    // while the block is idle, so a prediction made at acceptance is exact.
    logic signed [VALUE_BITS_DEF-1:0] plane_copy [2][PLANE_CELLS];
    logic [POS_BITS-1:0]  cell_idx   = '0;
    logic                 wr_bank    = 1'b0;
    logic                 have_prev  = 1'b0;
    logic [SIDE_BITS-1:0] cfg_side   = SIDE_LARGE;
    sym_t                 cfg_sym    = SYM_IDENTITY;

    // Handshake bookkeeping shared by the driver, the monitor and the sequence.
    logic        in_fire       = 1'b0;
    logic        out_fire      = 1'b0;
    int unsigned words_pushed  = 0;
    int unsigned words_taken   = 0;
    int unsigned results_seen  = 0;
    int unsigned fail_count    = 0;
    int unsigned stuck_cycles  = 0;

    // Knobs the sequence turns to shape idling on either side.
    logic        sender_paused = 1'b0;
    logic        tx_calm       = 1'b0;
    logic        rx_calm       = 1'b0;
    int unsigned tx_gap        = 0;
    int unsigned rx_stall      = 0;
    int unsigned rx_hold_len   = 0;

    // What the run covered, for the closing summary.
    int unsigned drains_taken  = 0;
    int unsigned error_results = 0;
    int unsigned filled_results = 0;
    int unsigned settings_done = 0;
    logic [15:0] sides_seen    = '0;
    logic [7:0]  syms_seen     = '0;

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Predicts the result word for one accepted input word and applies the
    // store write and the bank swap to our copy of the block state.
    function automatic permuted_cell_t permute_step(op_t op,
                                                    logic signed [VALUE_BITS_DEF-1:0] value);
        permuted_cell_t res;
        int unsigned    side, cells, pos, row, col, m, tr, tc;
        logic           rd_bank;
        res  = '0;
        side = cfg_side;
        // A side other than the two accepted ones leaves all state alone.
        if (!(cfg_side == SIDE_SMALL || cfg_side == SIDE_LARGE) || side > MAX_SIDE_DEF) begin
            res.position   = cell_idx;
            res.side_error = 1'b1;
            return res;
        end
        cells = side * side;
        // A side change in the middle of a plane can leave the index past the end.
        pos     = (cell_idx < cells) ? cell_idx : 0;
        rd_bank = ~wr_bank;
        res.value      = plane_copy[rd_bank][pos];
        res.position   = pos[POS_BITS-1:0];
        res.plane_end  = (pos == cells - 1);
        res.from_plane = have_prev;
        if (op == OP_CELL) begin
            row = pos / side;
            col = pos % side;
            m   = side - 1;
            case (cfg_sym)
                SYM_IDENTITY:   begin tr = row;     tc = col;     end
                SYM_ROT90:      begin tr = col;     tc = m - row; end
                SYM_ROT180:     begin tr = m - row; tc = m - col; end
                SYM_ROT270:     begin tr = m - col; tc = row;     end
                SYM_REFLECT:    begin tr = row;     tc = m - col; end
                SYM_REF_ROT90:  begin tr = m - col; tc = m - row; end
                SYM_REF_ROT180: begin tr = m - row; tc = col;     end
                default:        begin tr = col;     tc = row;     end
            endcase
            plane_copy[wr_bank][tr * side + tc] = value;
        end
        // The last position of a plane swaps the banks, whether its word is a cell or a drain.
        if (res.plane_end) begin
            cell_idx  = '0;
            wr_bank   = rd_bank;
            have_prev = 1'b1;
        end else begin
            cell_idx = POS_BITS'(pos + 1);
        end
        return res;
    endfunction

    // Input driver: a new word is chosen only once the current one has been
    // taken, so valid and payload hold steady while the block stalls.
    always @(negedge aclk) begin : feed_words
        cell_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (sender_paused || pending_words.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                w = pending_words.pop_front();
                s_valid      <= 1'b1;
                s_op         <= w.op;
                s_cell_value <= w.value;
                tx_gap = tx_calm ? 0 : idle_gap();
            end
        end
    end

    // Result side back-pressure. A forced hold-off outranks the random stalls
    // so the block's result queue fills and it has to stall its input.
    always @(negedge aclk) begin
        if (rx_hold_len > 0) begin
            rx_hold_len--;
            m_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_stall = rx_calm ? 0 : idle_gap();
        end
    end

    // Everything observed at the rising edge: predictions for accepted input
    // words, the check of accepted result words, and the watchdog.
    always @(posedge aclk) begin : watch_ports
        permuted_cell_t want;
        in_fire  = aresetn && s_valid && s_ready;
        out_fire = aresetn && m_valid && m_ready;
        if (in_fire) begin
            expected_results.push_back(permute_step(op_t'(s_op), s_cell_value));
            words_taken++;
            if (op_t'(s_op) == OP_DRAIN) drains_taken++;
        end
        if (out_fire) begin
            results_seen++;
            if (m_config_error) error_results++;
            if (m_out_valid) filled_results++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("mismatch: result word %0d arrived with nothing outstanding",
                             results_seen);
            end else begin
                want = expected_results.pop_front();
                if (m_out_value !== want.value || m_out_position !== want.position ||
                    m_plane_end !== want.plane_end || m_out_valid !== want.from_plane ||
                    m_config_error !== want.side_error) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch at result word %0d: expected %0d %0d %b %b %b",
                                 results_seen, want.value, want.position, want.plane_end,
                                 want.from_plane, want.side_error);
                        $display("    (value pos end valid err), got %0d %0d %b %b %b",
                                 m_out_value, m_out_position, m_plane_end, m_out_valid,
                                 m_config_error);
                    end
                end
            end
        end
        // Only cycles in which work is outstanding and nothing moves count.
        if (in_fire || out_fire || (words_taken == words_pushed && expected_results.size() == 0))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, expected_results.size());
            $display("FAIL square_grid_dihedral_permuter");
            $finish;
        end
    end

    task automatic push_word(op_t op, logic signed [VALUE_BITS_DEF-1:0] value);
        pending_words.push_back('{op: op, value: value});
        words_pushed++;
    endtask

    // Blocks until every queued word has been taken and every result has come.
    task automatic wait_idle();
        while (words_taken != words_pushed || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; the register is written at the
    // rising edge where penable and pready are both high.
    task automatic apb_write(reg_idx_t idx, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_BOARD_SIDE: cfg_side = data[SIDE_BITS-1:0];
            default:        cfg_sym  = sym_t'(data[2:0]);
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes both registers once the block has gone quiet. The upper data bits
    // are random; the block must ignore them.
    task automatic configure(logic [SIDE_BITS-1:0] side, sym_t sym);
        logic [31:0] data;
        wait_idle();
        data = $urandom();
        data[SIDE_BITS-1:0] = side;
        apb_write(REG_BOARD_SIDE, data);
        data = $urandom();
        data[2:0] = sym;
        apb_write(REG_SYMMETRY, data);
        sides_seen[side] = 1'b1;
        syms_seen[sym]   = 1'b1;
        settings_done++;
    endtask

    initial begin : sequence_main
        logic [SIDE_BITS-1:0] side;
        sym_t                 sym;
        int unsigned          n, pick, drain_pct, phase, random_words, start_taken;
        phase        = 0;
        random_words = 0;
        for (int b = 0; b < 2; b++)
            for (int i = 0; i < PLANE_CELLS; i++)
                plane_copy[b][i] = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. A side of 8 and other unaccepted sides must give error
        // results and leave the position where it was.
        configure(4'd8, SYM_IDENTITY);
        push_word(OP_CELL, 8'sh7f);
        push_word(OP_CELL, 8'sh80);
        configure(4'd15, SYM_REF_ROT270);
        push_word(OP_DRAIN, 8'sh00);
        push_word(OP_CELL, 8'shff);
        configure(4'd0, SYM_ROT180);
        push_word(OP_CELL, 8'sh01);

        // Small side with extreme values and a drain in the middle.
        configure(SIDE_SMALL, SYM_ROT90);
        push_word(OP_CELL, 8'sh7f);
        push_word(OP_CELL, 8'sh80);
        push_word(OP_CELL, 8'sh00);
        push_word(OP_CELL, 8'shff);
        push_word(OP_CELL, 8'sh55);
        push_word(OP_CELL, 8'shaa);
        push_word(OP_DRAIN, 8'sh5a);
        push_word(OP_CELL, 8'sh01);

        // Growing the side mid-plane keeps the position; running it past 49
        // and then shrinking the side must restart the plane at position 0.
        configure(SIDE_LARGE, SYM_REF_ROT180);
        push_word(OP_CELL, 8'sh80);
        push_word(OP_DRAIN, 8'sh00);
        push_word(OP_CELL, 8'sh7f);
        push_word(OP_CELL, 8'sh33);
        for (int i = 0; i < 40; i++)
            push_word(OP_CELL, VALUE_BITS_DEF'($urandom()));
        configure(SIDE_SMALL, SYM_REFLECT);
        push_word(OP_CELL, 8'sh80);
        push_word(OP_CELL, 8'sh7f);
        push_word(OP_DRAIN, 8'shc3);

        // Random part: mostly whole planes of random content under random
        // settings, with partial planes, drains and bad sides mixed in.
        while (random_words < RANDOM_WORDS) begin
            phase++;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                side = 4'd8;
            else if (pick < 14)
                side = SIDE_BITS'($urandom());
            else if (pick < 57)
                side = SIDE_SMALL;
            else
                side = SIDE_LARGE;
            sym = sym_t'($urandom_range(0, 7));
            if (phase == 4 || phase == 7)
                side = SIDE_LARGE;
            configure(side, sym);

            if (side != SIDE_SMALL && side != SIDE_LARGE)
                n = $urandom_range(1, 6);
            else if (phase == 4 || phase == 7)
                n = 2 * side * side;
            else if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, 40);
            else
                n = side * side * $urandom_range(1, 2);

            pick      = $urandom_range(0, 9);
            drain_pct = (pick < 6) ? 0 : (pick < 9) ? 10 : 60;
            tx_calm   = ($urandom_range(0, 3) == 0);
            rx_calm   = ($urandom_range(0, 3) == 0);

            start_taken = words_pushed;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 99) < drain_pct)
                    push_word(OP_DRAIN, VALUE_BITS_DEF'($urandom()));
                else
                    push_word(OP_CELL, VALUE_BITS_DEF'($urandom()));
            end
            random_words += n;

            if (phase == 4) begin
                // The receiver goes deaf while the sender keeps offering words.
                rx_hold_len = HOLD_CYCLES;
            end else if (phase == 7) begin
                // Halfway through the phase the sender stops until the block
                // has handed back every result it owes.
                while (words_taken < start_taken + n / 2) @(posedge aclk);
                sender_paused = 1'b1;
                while (s_valid || expected_results.size() != 0) @(posedge aclk);
                sender_paused = 1'b0;
            end
        end

        wait_idle();
        // Room for any stray result word to show up after the last real one.
        repeat (20) @(posedge aclk);
        fail_count += expected_results.size();

        $display("Covered %0d input words (%0d drains) over %0d register settings; %0d %s",
                 words_taken, drains_taken, settings_done, results_seen, "result words seen.");
        $display("%0d results came from a finished plane, %0d flagged a bad side %s%h, %s%h.",
                 filled_results, error_results, "(sides written mask ", sides_seen,
                 "symmetries mask ", syms_seen);
        if (fail_count == 0) begin
            $display("PASS square_grid_dihedral_permuter");
        end else begin
            $display("%0d failures", fail_count);
            $display("FAIL square_grid_dihedral_permuter");
        end
        $finish;
    end

endmodule
